@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

@@ sv/lcdbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdbs_pkg
// Types and codes shared by the LCD 4-bit bus sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdbs_pkg;

  localparam int ENABLE_LINES = 3;

  localparam logic [7:0] PULSE_RESET = 8'd1;
  localparam logic       BUSY_RESET  = 1'b1;
  localparam logic [7:0] RETRY_RESET = 8'd100;

  // actions
  localparam logic [1:0] ACT_TICK       = 2'd0;
  localparam logic [1:0] ACT_NIBBLE_WR  = 2'd1;
  localparam logic [1:0] ACT_BYTE_WR    = 2'd2;
  localparam logic [1:0] ACT_BYTE_RD    = 2'd3;

  // wait modes
  localparam logic [1:0] WAIT_FIXED     = 2'd0;
  localparam logic [1:0] WAIT_POLL      = 2'd1;
  localparam logic [1:0] WAIT_POLL_LIM  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_PULSE      = 2'd0;
  localparam logic [1:0] CFG_BUSY_LEVEL = 2'd1;
  localparam logic [1:0] CFG_RETRY      = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  enable_select;
    logic [7:0]  write_data;
    logic        reg_select;
    logic [1:0]  wait_mode;
    logic [15:0] wait_ticks;
    logic [3:0]  pins_in;
  } in_item_t;

  typedef struct packed {
    logic [ENABLE_LINES-1:0] enable_lines;
    logic                    rs_out;
    logic                    rw_out;
    logic [3:0]              pins_out;
    logic                    pins_drive;
    logic                    ready_res;
    logic                    done_res;
    logic [7:0]              read_byte;
    logic [6:0]              address_counter;
    logic                    timeout_error;
  } out_item_t;

  typedef struct packed {
    logic      accept;
    out_item_t item;
  } result_t;

endpackage

`default_nettype wire

@@ sv/lcdbs_core.sv @@
// ----------------------------------------------------------------------------
// lcdbs_core
// Sequencer state and configuration; one step per accepted transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdbs_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire logic               accept,
  input  wire lcdbs_pkg::in_item_t item,
  output lcdbs_pkg::result_t      result
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAIT, PH_POLL_HI1, PH_POLL_LO1, PH_POLL_HI2, PH_POLL_END,
    PH_WR_HI, PH_WR_END, PH_RD_HI, PH_RD_END
  } phase_t;

  logic [7:0]  enable_pulse_us;
  logic        busy_level;
  logic [7:0]  retry_limit;

  phase_t      phase, phase_next;
  logic [15:0] delay_count, delay_count_next;
  logic [7:0]  retry_count, retry_count_next;
  logic [7:0]  op_data, op_data_next;
  logic [1:0]  op_sel, op_sel_next;
  logic        op_rs, op_rs_next;
  logic [1:0]  op_mode, op_mode_next;
  logic [1:0]  op_kind, op_kind_next;
  logic        op_second, op_second_next;
  logic [15:0] wait_latch, wait_latch_next;
  logic [7:0]  assembled_byte, assembled_byte_next;
  logic [6:0]  ac_latch, ac_latch_next;
  logic        busy_seen, busy_seen_next;

  always_comb begin
    logic [15:0] pulse_m1;
    logic [lcdbs_pkg::ENABLE_LINES-1:0] en_mask;
    logic [lcdbs_pkg::ENABLE_LINES-1:0] en;
    logic [3:0]  nibble;
    logic        rs_o, rw_o, drive, done, tmo, do_prewrite, do_poll;
    logic [3:0]  pout;

    pulse_m1 = (enable_pulse_us == 8'd0) ? 16'd0 : {8'd0, enable_pulse_us - 8'd1};
    for (int i = 0; i < lcdbs_pkg::ENABLE_LINES; i++) begin
      en_mask[i] = (int'(op_sel) == i);
    end
    nibble = (op_kind == lcdbs_pkg::ACT_BYTE_WR && !op_second) ? op_data[7:4] : op_data[3:0];

    en    = '0;
    rs_o  = 1'b0;
    rw_o  = 1'b0;
    pout  = 4'd0;
    drive = 1'b1;
    unique case (phase)
      PH_POLL_HI1, PH_POLL_HI2: begin
        en = en_mask; rw_o = 1'b1; drive = 1'b0;
      end
      PH_POLL_LO1: begin
        rw_o = 1'b1; drive = 1'b0;
      end
      PH_WR_HI: begin
        en = en_mask; rs_o = op_rs; pout = nibble;
      end
      PH_WR_END: begin
        rs_o = op_rs; pout = nibble;
      end
      PH_RD_HI: begin
        en = en_mask; rs_o = op_rs; rw_o = 1'b1; drive = 1'b0;
      end
      PH_RD_END: begin
        rs_o = op_rs; rw_o = 1'b1; drive = 1'b0;
      end
      default: begin
      end
    endcase

    phase_next          = phase;
    delay_count_next    = delay_count;
    retry_count_next    = retry_count;
    op_data_next        = op_data;
    op_sel_next         = op_sel;
    op_rs_next          = op_rs;
    op_mode_next        = op_mode;
    op_kind_next        = op_kind;
    op_second_next      = op_second;
    wait_latch_next     = wait_latch;
    assembled_byte_next = assembled_byte;
    ac_latch_next       = ac_latch;
    busy_seen_next      = busy_seen;
    done        = 1'b0;
    tmo         = 1'b0;
    do_prewrite = 1'b0;
    do_poll     = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (item.action != lcdbs_pkg::ACT_TICK) begin
          op_data_next    = item.write_data;
          op_sel_next     = item.enable_select;
          op_rs_next      = item.reg_select;
          op_mode_next    = item.wait_mode;
          op_kind_next    = item.action;
          op_second_next  = 1'b0;
          wait_latch_next = item.wait_ticks;
          if (item.action == lcdbs_pkg::ACT_BYTE_RD) begin
            do_poll = 1'b1;
          end else begin
            do_prewrite = 1'b1;
          end
        end
      end
      PH_WAIT: begin
        if (delay_count == 16'd0) begin
          phase_next = PH_WR_HI; delay_count_next = pulse_m1;
        end else begin
          delay_count_next = delay_count - 16'd1;
        end
      end
      PH_POLL_HI1: begin
        if (delay_count == 16'd0) begin
          busy_seen_next   = (item.pins_in[3] == busy_level);
          ac_latch_next    = {item.pins_in[2:0], 4'd0};
          phase_next       = PH_POLL_LO1;
          delay_count_next = pulse_m1;
        end else begin
          delay_count_next = delay_count - 16'd1;
        end
      end
      PH_POLL_LO1: begin
        if (delay_count == 16'd0) begin
          phase_next = PH_POLL_HI2; delay_count_next = pulse_m1;
        end else begin
          delay_count_next = delay_count - 16'd1;
        end
      end
      PH_POLL_HI2: begin
        if (delay_count == 16'd0) begin
          ac_latch_next    = {ac_latch[6:4], item.pins_in};
          phase_next       = PH_POLL_END;
          delay_count_next = 16'd0;
        end else begin
          delay_count_next = delay_count - 16'd1;
        end
      end
      PH_POLL_END: begin
        if (!busy_seen) begin
          phase_next = (op_kind == lcdbs_pkg::ACT_BYTE_RD) ? PH_RD_HI : PH_WR_HI;
          delay_count_next = pulse_m1;
        end else if (op_kind == lcdbs_pkg::ACT_BYTE_RD || op_mode != lcdbs_pkg::WAIT_POLL) begin
          if (retry_count >= retry_limit) begin
            done = 1'b1; tmo = 1'b1; phase_next = PH_IDLE;
          end else begin
            retry_count_next = retry_count + 8'd1;
            phase_next       = PH_POLL_HI1;
            delay_count_next = pulse_m1;
          end
        end else begin
          phase_next = PH_POLL_HI1; delay_count_next = pulse_m1;
        end
      end
      PH_WR_HI: begin
        if (delay_count == 16'd0) begin
          phase_next = PH_WR_END; delay_count_next = 16'd0;
        end else begin
          delay_count_next = delay_count - 16'd1;
        end
      end
      PH_WR_END: begin
        if (op_kind == lcdbs_pkg::ACT_BYTE_WR && !op_second) begin
          op_second_next = 1'b1;
          do_prewrite    = 1'b1;
        end else begin
          done = 1'b1; phase_next = PH_IDLE;
        end
      end
      PH_RD_HI: begin
        if (delay_count == 16'd0) begin
          if (!op_second) begin
            assembled_byte_next = {item.pins_in, 4'd0};
          end else begin
            assembled_byte_next = {assembled_byte[7:4], item.pins_in};
          end
          phase_next = PH_RD_END; delay_count_next = 16'd0;
        end else begin
          delay_count_next = delay_count - 16'd1;
        end
      end
      PH_RD_END: begin
        if (!op_second) begin
          op_second_next = 1'b1; phase_next = PH_RD_HI; delay_count_next = pulse_m1;
        end else begin
          done = 1'b1; phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (do_prewrite) begin
      ac_latch_next  = 7'd0;
      busy_seen_next = 1'b0;
      if (op_mode_next == lcdbs_pkg::WAIT_FIXED) begin
        if (wait_latch_next == 16'd0) begin
          phase_next = PH_WR_HI; delay_count_next = pulse_m1;
        end else begin
          phase_next = PH_WAIT; delay_count_next = wait_latch_next - 16'd1;
        end
      end else begin
        do_poll = 1'b1;
      end
    end
    if (do_poll) begin
      ac_latch_next    = 7'd0;
      busy_seen_next   = 1'b0;
      retry_count_next = 8'd0;
      phase_next       = PH_POLL_HI1;
      delay_count_next = pulse_m1;
    end

    if (!drive) begin
      pout = 4'd0;
    end

    result.accept                = accept;
    result.item.enable_lines     = en;
    result.item.rs_out           = rs_o;
    result.item.rw_out           = rw_o;
    result.item.pins_out         = pout;
    result.item.pins_drive       = drive;
    result.item.ready_res        = (phase == PH_IDLE);
    result.item.done_res         = done;
    result.item.read_byte        = assembled_byte_next;
    result.item.address_counter  = ac_latch_next;
    result.item.timeout_error    = tmo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_pulse_us <= lcdbs_pkg::PULSE_RESET;
      busy_level      <= lcdbs_pkg::BUSY_RESET;
      retry_limit     <= lcdbs_pkg::RETRY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcdbs_pkg::CFG_PULSE:      enable_pulse_us <= cfg_data;
        lcdbs_pkg::CFG_BUSY_LEVEL: busy_level      <= cfg_data[0];
        lcdbs_pkg::CFG_RETRY:      retry_limit     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      delay_count    <= '0;
      retry_count    <= '0;
      op_data        <= '0;
      op_sel         <= '0;
      op_rs          <= 1'b0;
      op_mode        <= '0;
      op_kind        <= '0;
      op_second      <= 1'b0;
      wait_latch     <= '0;
      assembled_byte <= '0;
      ac_latch       <= '0;
      busy_seen      <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      delay_count    <= delay_count_next;
      retry_count    <= retry_count_next;
      op_data        <= op_data_next;
      op_sel         <= op_sel_next;
      op_rs          <= op_rs_next;
      op_mode        <= op_mode_next;
      op_kind        <= op_kind_next;
      op_second      <= op_second_next;
      wait_latch     <= wait_latch_next;
      assembled_byte <= assembled_byte_next;
      ac_latch       <= ac_latch_next;
      busy_seen      <= busy_seen_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/lcdbs_out_stage.sv @@
// ----------------------------------------------------------------------------
// lcdbs_out_stage
// Output register with a skid entry; stall towards the input is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdbs_out_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lcdbs_pkg::result_t  result,
  output logic                     skid_full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lcdbs_pkg::out_item_t     out_data
);

  logic                 skid_valid;
  lcdbs_pkg::out_item_t skid_data;
  logic                 load_main, load_skid, move_skid;

  assign skid_full = skid_valid;
  assign move_skid = skid_valid && !out_stall;
  assign load_skid = result.accept && out_valid && out_stall;
  assign load_main = result.accept && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (move_skid) begin
        skid_valid <= 1'b0;
      end
    end else if (load_skid) begin
      skid_valid <= 1'b1;
    end else if (load_main) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_skid) begin
      out_data <= skid_data;
    end else if (load_main) begin
      out_data <= result.item;
    end
    if (load_skid) begin
      skid_data <= result.item;
    end
  end

endmodule

`default_nettype wire

@@ sv/lcd_4bit_bus_sequencer.sv @@
// Each result is registered at the output or first held in the skid entry on stall.
// One transaction per cycle unless in_stall; the sequencer takes one step per tick.
// A two-entry output buffer keeps accepting input on stall until the skid entry fills.
// Reset (rst, synchronous): sequencer idle, registers at reset values, no result held.
// ----------------------------------------------------------------------------
// lcd_4bit_bus_sequencer
// Character-LCD 4-bit bus master, one step per microsecond tick transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_4bit_bus_sequencer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lcdbs_pkg::in_item_t in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lcdbs_pkg::out_item_t     out_data
);

  lcdbs_pkg::result_t result;
  logic               skid_full;

  assign in_stall = skid_full;

  lcdbs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (in_valid && !skid_full),
    .item      (in_data),
    .result    (result)
  );

  lcdbs_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .skid_full (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ sv/lcdbs_checker.sv @@
// ----------------------------------------------------------------------------
// lcdbs_checker
// Port-level checks on the sequencer outputs, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lcdbs_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire lcdbs_pkg::out_item_t out_data
);

  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled transaction changed")
  `ASSERT_IMPLY(a_tmo_done, out_valid && out_data.timeout_error, out_data.done_res, "timeout without done")
  `ASSERT_IMPLY(a_en_onehot, out_valid, $onehot0(out_data.enable_lines), "more than one enable line")
  `ASSERT_IMPLY(a_pins_released, out_valid && !out_data.pins_drive, out_data.pins_out == 4'd0, "released pins not zero")

endmodule

bind lcd_4bit_bus_sequencer lcdbs_checker u_checker (.*);

`default_nettype wire

@@ sim/tb_lcd_4bit_bus_sequencer.sv @@
// ----------------------------------------------------------------------------
// tb_lcd_4bit_bus_sequencer
// Self-checking bench for the LCD 4-bit bus sequencer. Each tick transaction
// runs through a cycle-exact model of the sequencer. The model's pin levels
// are queued and compared field by field with every result that leaves the
// block. A directed pass covers the operations, wait modes, timeouts, the
// unused select and a long fixed delay. Random phases then run
// well-formed operations with busy polls steered through D7, plus stray
// starts, under several register settings and random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lcd_4bit_bus_sequencer;

  localparam logic [1:0] WAIT_SPARE = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WAIT, PH_POLL_HI1, PH_POLL_LO1, PH_POLL_HI2, PH_POLL_END,
    PH_WR_HI, PH_WR_END, PH_RD_HI, PH_RD_END
  } seq_phase_e;

  class bus_scoreboard;
    logic [7:0]  pulse_us;
    logic        busy_lvl;
    logic [7:0]  retry_lim;
    seq_phase_e  ph;
    logic [15:0] dly;
    logic [7:0]  retries;
    logic [7:0]  op_data;
    logic [1:0]  op_sel;
    logic        op_rs;
    logic [1:0]  op_mode;
    logic [1:0]  op_kind;
    logic        op_second;
    logic [15:0] op_wait;
    logic [7:0]  rd_byte;
    logic [6:0]  ac;
    logic        busy_flag;
    lcdbs_pkg::out_item_t pin_levels_q[$];
    int          errors;
    int          n_checked;
    int          n_done;
    int          n_timeouts;
    int          n_reads;

    function new();
      pulse_us  = lcdbs_pkg::PULSE_RESET;
      busy_lvl  = lcdbs_pkg::BUSY_RESET;
      retry_lim = lcdbs_pkg::RETRY_RESET;
      ph        = PH_IDLE;
      dly       = '0;
      retries   = '0;
      op_data   = '0;
      op_sel    = '0;
      op_rs     = 1'b0;
      op_mode   = '0;
      op_kind   = '0;
      op_second = 1'b0;
      op_wait   = '0;
      rd_byte   = '0;
      ac        = '0;
      busy_flag = 1'b0;
    endfunction

    function void write_cfg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        lcdbs_pkg::CFG_PULSE:      pulse_us  = val;
        lcdbs_pkg::CFG_BUSY_LEVEL: busy_lvl  = val[0];
        lcdbs_pkg::CFG_RETRY:      retry_lim = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pin_levels_q.size();
    endfunction

    function bit is_idle();
      return ph == PH_IDLE;
    endfunction

    function bit at_busy_sample();
      return ph == PH_POLL_HI1 && dly == 0;
    endfunction

    function int pulse_len();
      return (pulse_us == 0) ? 1 : int'(pulse_us);
    endfunction

    function void enter(seq_phase_e p, int len);
      ph  = p;
      dly = 16'(len - 1);
    endfunction

    function bit phase_over();
      if (dly == 0) return 1'b1;
      dly--;
      return 1'b0;
    endfunction

    function logic [3:0] nibble();
      if (op_kind == lcdbs_pkg::ACT_BYTE_WR && !op_second) return op_data[7:4];
      return op_data[3:0];
    endfunction

    function void start_poll();
      ac        = '0;
      busy_flag = 1'b0;
      retries   = '0;
      enter(PH_POLL_HI1, pulse_len());
    endfunction

    function void prewrite();
      ac        = '0;
      busy_flag = 1'b0;
      if (op_mode == lcdbs_pkg::WAIT_FIXED) begin
        if (op_wait == 0) enter(PH_WR_HI, pulse_len());
        else enter(PH_WAIT, int'(op_wait));
      end else begin
        start_poll();
      end
    endfunction

    // advance one tick and queue the pin levels of that tick
    function void note_tick(lcdbs_pkg::in_item_t it);
      lcdbs_pkg::out_item_t               r;
      logic [lcdbs_pkg::ENABLE_LINES-1:0] mask;
      mask = '0;
      if (op_sel < lcdbs_pkg::ENABLE_LINES) mask[op_sel] = 1'b1;
      r = '0;
      r.pins_drive = 1'b1;
      r.ready_res  = (ph == PH_IDLE);
      case (ph)
        PH_POLL_HI1, PH_POLL_HI2: begin
          r.enable_lines = mask;
          r.rw_out       = 1'b1;
          r.pins_drive   = 1'b0;
        end
        PH_POLL_LO1: begin
          r.rw_out     = 1'b1;
          r.pins_drive = 1'b0;
        end
        PH_WR_HI: begin
          r.enable_lines = mask;
          r.rs_out       = op_rs;
          r.pins_out     = nibble();
        end
        PH_WR_END: begin
          r.rs_out   = op_rs;
          r.pins_out = nibble();
        end
        PH_RD_HI: begin
          r.enable_lines = mask;
          r.rs_out       = op_rs;
          r.rw_out       = 1'b1;
          r.pins_drive   = 1'b0;
        end
        PH_RD_END: begin
          r.rs_out     = op_rs;
          r.rw_out     = 1'b1;
          r.pins_drive = 1'b0;
        end
        default: ;
      endcase

      case (ph)
        PH_IDLE: begin
          if (it.action != lcdbs_pkg::ACT_TICK) begin
            op_data   = it.write_data;
            op_sel    = it.enable_select;
            op_rs     = it.reg_select;
            op_mode   = it.wait_mode;
            op_kind   = it.action;
            op_second = 1'b0;
            op_wait   = it.wait_ticks;
            if (it.action == lcdbs_pkg::ACT_BYTE_RD) start_poll();
            else prewrite();
          end
        end
        PH_WAIT: begin
          if (phase_over()) enter(PH_WR_HI, pulse_len());
        end
        PH_POLL_HI1: begin
          if (phase_over()) begin
            busy_flag = (it.pins_in[3] == busy_lvl);
            ac        = {it.pins_in[2:0], 4'b0000};
            enter(PH_POLL_LO1, pulse_len());
          end
        end
        PH_POLL_LO1: begin
          if (phase_over()) enter(PH_POLL_HI2, pulse_len());
        end
        PH_POLL_HI2: begin
          if (phase_over()) begin
            ac[3:0] = it.pins_in;
            enter(PH_POLL_END, 1);
          end
        end
        PH_POLL_END: begin
          if (!busy_flag) begin
            enter((op_kind == lcdbs_pkg::ACT_BYTE_RD) ? PH_RD_HI : PH_WR_HI, pulse_len());
          end else if (op_kind == lcdbs_pkg::ACT_BYTE_RD ||
                       op_mode != lcdbs_pkg::WAIT_POLL) begin
            if (retries >= retry_lim) begin
              r.done_res      = 1'b1;
              r.timeout_error = 1'b1;
              ph              = PH_IDLE;
            end else begin
              retries++;
              enter(PH_POLL_HI1, pulse_len());
            end
          end else begin
            enter(PH_POLL_HI1, pulse_len());
          end
        end
        PH_WR_HI: begin
          if (phase_over()) enter(PH_WR_END, 1);
        end
        PH_WR_END: begin
          if (op_kind == lcdbs_pkg::ACT_BYTE_WR && !op_second) begin
            op_second = 1'b1;
            prewrite();
          end else begin
            r.done_res = 1'b1;
            ph         = PH_IDLE;
          end
        end
        PH_RD_HI: begin
          if (phase_over()) begin
            if (!op_second) rd_byte = {it.pins_in, 4'b0000};
            else rd_byte[3:0] = it.pins_in;
            enter(PH_RD_END, 1);
          end
        end
        PH_RD_END: begin
          if (!op_second) begin
            op_second = 1'b1;
            enter(PH_RD_HI, pulse_len());
          end else begin
            r.done_res = 1'b1;
            ph         = PH_IDLE;
            n_reads++;
          end
        end
        default: ph = PH_IDLE;
      endcase

      if (r.done_res) n_done++;
      if (r.timeout_error) n_timeouts++;
      r.read_byte       = rd_byte;
      r.address_counter = ac;
      pin_levels_q.push_back(r);
    endfunction

    function void cmp(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        if (errors < 200) $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_levels(lcdbs_pkg::out_item_t got);
      lcdbs_pkg::out_item_t want;
      n_checked++;
      if (pin_levels_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
        return;
      end
      want = pin_levels_q.pop_front();
      cmp("enable_lines", 16'(want.enable_lines), 16'(got.enable_lines));
      cmp("rs_out", 16'(want.rs_out), 16'(got.rs_out));
      cmp("rw_out", 16'(want.rw_out), 16'(got.rw_out));
      cmp("pins_out", 16'(want.pins_out), 16'(got.pins_out));
      cmp("pins_drive", 16'(want.pins_drive), 16'(got.pins_drive));
      cmp("ready_res", 16'(want.ready_res), 16'(got.ready_res));
      cmp("done_res", 16'(want.done_res), 16'(got.done_res));
      cmp("read_byte", 16'(want.read_byte), 16'(got.read_byte));
      cmp("address_counter", 16'(want.address_counter), 16'(got.address_counter));
      cmp("timeout_error", 16'(want.timeout_error), 16'(got.timeout_error));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  lcdbs_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  lcdbs_pkg::out_item_t out_data;

  bus_scoreboard sb;
  bit            idling;
  bit            stray_starts;
  bit            noisy_busy;
  int            busy_left;
  int            stall_left;
  int            n_items;
  int            spins;

  lcd_4bit_bus_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) sb.check_levels(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_tick(lcdbs_pkg::in_item_t it);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_tick(it);
  endtask

  // hold the sender until every expected transaction has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] pulse, logic lvl, logic [7:0] retry);
    cfg_we    <= 1'b1;
    cfg_index <= lcdbs_pkg::CFG_PULSE;
    cfg_data  <= pulse;
    @(posedge clk);
    cfg_index <= lcdbs_pkg::CFG_BUSY_LEVEL;
    cfg_data  <= {7'd0, lvl};
    @(posedge clk);
    cfg_index <= lcdbs_pkg::CFG_RETRY;
    cfg_data  <= retry;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_cfg(lcdbs_pkg::CFG_PULSE, pulse);
    sb.write_cfg(lcdbs_pkg::CFG_BUSY_LEVEL, {7'd0, lvl});
    sb.write_cfg(lcdbs_pkg::CFG_RETRY, retry);
  endtask

  // random tick; unless noisy, D7 steers the busy flag at each poll sample
  function automatic lcdbs_pkg::in_item_t make_tick();
    logic [63:0]         raw;
    lcdbs_pkg::in_item_t it;
    raw       = {$urandom(), $urandom()};
    it        = raw[34:0];
    it.action = lcdbs_pkg::ACT_TICK;
    if (sb.at_busy_sample() && !noisy_busy) begin
      if (busy_left > 0) begin
        it.pins_in[3] = sb.busy_lvl;
        busy_left--;
      end else begin
        it.pins_in[3] = ~sb.busy_lvl;
      end
    end
    return it;
  endfunction

  function automatic lcdbs_pkg::in_item_t op_item(logic [1:0] act, logic [1:0] sel,
                                                  logic [7:0] data, logic rs,
                                                  logic [1:0] mode, logic [15:0] wt);
    lcdbs_pkg::in_item_t it;
    it.action        = act;
    it.enable_select = sel;
    it.write_data    = data;
    it.reg_select    = rs;
    it.wait_mode     = mode;
    it.wait_ticks    = wt;
    it.pins_in       = 4'($urandom_range(0, 15));
    return it;
  endfunction

  task automatic run_op(lcdbs_pkg::in_item_t start, int polls, bit noise);
    lcdbs_pkg::in_item_t it;
    busy_left  = polls;
    noisy_busy = noise;
    send_tick(start);
    n_items++;
    while (!sb.is_idle()) begin
      it = make_tick();
      if (stray_starts && $urandom_range(0, 7) == 0) it.action = 2'($urandom_range(1, 3));
      else n_items++;
      send_tick(it);
    end
  endtask

  task automatic random_op(int wt_big, int poll_cap);
    logic [63:0]         raw;
    lcdbs_pkg::in_item_t st;
    int                  pick;
    int                  polls;
    bit                  limited;
    raw       = {$urandom(), $urandom()};
    st        = raw[34:0];
    st.action = 2'($urandom_range(1, 3));
    if ($urandom_range(0, 15) == 0) st.wait_ticks = 16'($urandom_range(0, wt_big));
    else st.wait_ticks = 16'($urandom_range(0, 12));
    limited = (st.action == lcdbs_pkg::ACT_BYTE_RD) || (st.wait_mode != lcdbs_pkg::WAIT_POLL);
    pick    = $urandom_range(0, 9);
    if (pick < 5) polls = 0;
    else if (pick < 8) polls = $urandom_range(1, poll_cap);
    else if (pick == 8 && limited) polls = int'(sb.retry_lim) + 1;
    else polls = $urandom_range(0, poll_cap);
    run_op(st, polls, pick == 9);
  endtask

  task automatic random_phase(int budget, int wt_big, int poll_cap);
    n_items = 0;
    while (n_items < budget) begin
      if ($urandom_range(0, 3) == 0) begin
        noisy_busy = 1'b1;
        send_tick(make_tick());
        n_items++;
      end else begin
        random_op(wt_big, poll_cap);
      end
    end
    drain();
  endtask

  initial begin
    lcdbs_pkg::in_item_t it;
    sb           = new();
    idling       = 1'b0;
    stray_starts = 1'b0;
    noisy_busy   = 1'b1;
    busy_left    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    it        = '1;
    it.action = lcdbs_pkg::ACT_TICK;
    send_tick(it);
    send_tick('0);
    run_op(op_item(lcdbs_pkg::ACT_NIBBLE_WR, 2'd0, 8'hFF, 1'b1, lcdbs_pkg::WAIT_FIXED,
                   16'd0), 0, 1'b0);
    run_op(op_item(lcdbs_pkg::ACT_BYTE_WR, 2'd2, 8'hA5, 1'b0, lcdbs_pkg::WAIT_FIXED,
                   16'd3), 0, 1'b0);
    run_op(op_item(lcdbs_pkg::ACT_BYTE_RD, 2'd1, 8'h00, 1'b1, lcdbs_pkg::WAIT_FIXED,
                   16'd0), 0, 1'b0);
    run_op(op_item(lcdbs_pkg::ACT_NIBBLE_WR, 2'd1, 8'h3C, 1'b0, lcdbs_pkg::WAIT_POLL,
                   16'd0), 3, 1'b0);
    run_op(op_item(lcdbs_pkg::ACT_BYTE_WR, 2'd0, 8'h5A, 1'b1, lcdbs_pkg::WAIT_POLL_LIM,
                   16'd0), 2, 1'b0);
    run_op(op_item(lcdbs_pkg::ACT_BYTE_WR, 2'd1, 8'h00, 1'b0, WAIT_SPARE, 16'd0), 1, 1'b0);
    run_op(op_item(lcdbs_pkg::ACT_BYTE_RD, 2'd2, 8'hFF, 1'b0, lcdbs_pkg::WAIT_POLL,
                   16'hFFFF), int'(lcdbs_pkg::RETRY_RESET) + 1, 1'b0);
    run_op(op_item(lcdbs_pkg::ACT_NIBBLE_WR, 2'd2, 8'h0F, 1'b1, lcdbs_pkg::WAIT_POLL_LIM,
                   16'd0), int'(lcdbs_pkg::RETRY_RESET) + 1, 1'b0);
    run_op(op_item(lcdbs_pkg::ACT_BYTE_RD, 2'd3, 8'h00, 1'b1, lcdbs_pkg::WAIT_POLL_LIM,
                   16'd0), 1, 1'b0);
    run_op(op_item(lcdbs_pkg::ACT_BYTE_WR, 2'd3, 8'h96, 1'b0, lcdbs_pkg::WAIT_FIXED,
                   16'd1), 0, 1'b0);
    stray_starts = 1'b1;
    run_op(op_item(lcdbs_pkg::ACT_BYTE_WR, 2'd1, 8'hC3, 1'b1, lcdbs_pkg::WAIT_FIXED,
                   16'd5), 1, 1'b0);
    stray_starts = 1'b0;
    run_op(op_item(lcdbs_pkg::ACT_NIBBLE_WR, 2'd0, 8'h81, 1'b0, lcdbs_pkg::WAIT_FIXED,
                   16'd20), 0, 1'b0);
    drain();

    idling       = 1'b1;
    stray_starts = 1'b1;
    random_phase(100, 300, 3);
    set_config(8'd3, 1'b0, 8'd0);
    random_phase(120, 300, 3);
    set_config(8'd0, 1'b1, 8'd30);
    random_phase(120, 300, 3);
    set_config(8'd16, 1'b0, 8'd2);
    random_phase(80, 4, 1);
    set_config(8'd2, 1'b1, 8'd1);
    idling = 1'b0;
    random_phase(120, 300, 3);

    spins = 0;
    while (sb.pending() != 0 && spins < 2000) begin
      @(posedge clk);
      spins++;
    end
    if (sb.pending() != 0) begin
      $error("%0d expected transactions never arrived", sb.pending());
      sb.errors++;
    end
    repeat (8) @(posedge clk);

    $display("Checked %0d tick transactions over five register settings", sb.n_checked);
    $display("Operations finished: %0d, reads: %0d, busy timeouts: %0d",
             sb.n_done, sb.n_reads, sb.n_timeouts);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
